FILE: rtl/core/tfn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfn_pkg
// Widths, payload types and stage records shared by the face normal pipeline.
// ----------------------------------------------------------------------------
package tfn_pkg;

    localparam int COORD_WIDTH  = 24;
    localparam int NORMAL_WIDTH = 16;
    localparam int FRAC_OUT     = NORMAL_WIDTH - 2;

    localparam int EDGE_W  = COORD_WIDTH + 1;
    localparam int PROD_W  = 2 * EDGE_W;
    localparam int CROSS_W = PROD_W + 1;
    localparam int MAG_W   = PROD_W;
    localparam int HALF_W  = (MAG_W + 1) / 2;
    localparam int HI_W    = MAG_W - HALF_W;
    localparam int SQ_W    = 2 * MAG_W;
    localparam int SUM_W   = SQ_W + 2;
    localparam int ACC_W   = SQ_W + 2 * FRAC_OUT + 8;
    localparam int Q_W     = FRAC_OUT + 1;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] v0_x;
        logic signed [COORD_WIDTH-1:0] v0_y;
        logic signed [COORD_WIDTH-1:0] v0_z;
        logic signed [COORD_WIDTH-1:0] v1_x;
        logic signed [COORD_WIDTH-1:0] v1_y;
        logic signed [COORD_WIDTH-1:0] v1_z;
        logic signed [COORD_WIDTH-1:0] v2_x;
        logic signed [COORD_WIDTH-1:0] v2_y;
        logic signed [COORD_WIDTH-1:0] v2_z;
    } t_tri;

    typedef struct packed {
        logic signed [NORMAL_WIDTH-1:0] normal_x;
        logic signed [NORMAL_WIDTH-1:0] normal_y;
        logic signed [NORMAL_WIDTH-1:0] normal_z;
        logic                           degenerate;
    } t_norm;

    // cross product magnitudes and signs, components in order x, y, z
    typedef struct packed {
        logic [2:0][MAG_W-1:0] mag;
        logic [2:0]            neg;
        logic                  deg;
    } t_mag;

    // root search record: remainder, running m*S, partial quotient, S, signs, degenerate flag
    typedef struct packed {
        logic [2:0][ACC_W-1:0] rem;
        logic [2:0][ACC_W-1:0] ms;
        logic [2:0][Q_W-1:0]   q;
        logic [SUM_W-1:0]      s;
        logic [2:0]            neg;
        logic                  deg;
    } t_root;

endpackage

FILE: rtl/core/triangle_face_normal_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// triangle_face_normal_core
// Unit face normal of a triangle: cross product of edges v1-v0 and v2-v0, scaled to unit
// length and rounded to nearest (ties away from zero) in signed Q1.14.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake              | payload
//  ---------+-----------+------------------------+---------------------------
//  vertices | in        | i_valid / o_stall      | i_tri  (t_tri, 9 x 24 bit)
//  normal   | out       | o_valid / i_stall      | o_norm (t_norm, 3 x 16 + 1)
//
//  One beat enters per cycle while no stall is held; the pipe has 4 front stages, 4 square
//  stages, 15 quotient stages (one per result bit) and the output register.
//  The quotient stages set the depth: each resolves one bit with a wide
//  add and compare.
//  Reset clears only the valid bits; payload registers are not reset.
//  A stall from downstream freezes every stage at once, so no beat is lost
//  or repeated; o_stall is raised only while a result waits and i_stall is high.
// ----------------------------------------------------------------------------
module triangle_face_normal_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  tfn_pkg::t_tri  i_tri,
    output logic           o_valid,
    input  logic           i_stall,
    output tfn_pkg::t_norm o_norm
);
    import tfn_pkg::*;

    localparam logic signed [NORMAL_WIDTH-1:0] UNIT = NORMAL_WIDTH'(1) << FRAC_OUT;

    logic  en;
    logic  front_valid;
    t_mag  front_mag;
    logic  step_valid [Q_W+1];
    t_root step_root  [Q_W+1];
    logic  r_out_valid;
    t_norm r_norm;
    t_norm n_norm;
    t_root last_root;
    logic [NORMAL_WIDTH-1:0] qv [3];
    logic [NORMAL_WIDTH-1:0] sv [3];

    // Advance the whole pipe unless a finished beat is held by downstream.
    assign en      = !(r_out_valid && i_stall);
    assign o_stall = r_out_valid && i_stall;

    tfn_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_tri   (i_tri),
        .o_valid (front_valid),
        .o_mag   (front_mag)
    );

    tfn_square u_square (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (front_valid),
        .i_mag   (front_mag),
        .o_valid (step_valid[0]),
        .o_root  (step_root[0])
    );

    // Resolve quotient bits from the top one (value 1.0) down to the LSB.
    for (genvar g = 0; g < Q_W; g++) begin : g_step
        tfn_root_step #(
            .K (FRAC_OUT - g)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (step_valid[g]),
            .i_root  (step_root[g]),
            .o_valid (step_valid[g+1]),
            .o_root  (step_root[g+1])
        );
    end

    assign last_root = step_root[Q_W];

    // Apply the sign; drop the result to zero for a degenerate triangle.
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            qv[j] = NORMAL_WIDTH'(last_root.q[j]);
            sv[j] = last_root.deg ? '0 : (last_root.neg[j] ? -qv[j] : qv[j]);
        end
        n_norm.normal_x   = sv[0];
        n_norm.normal_y   = sv[1];
        n_norm.normal_z   = sv[2];
        n_norm.degenerate = last_root.deg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= step_valid[Q_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_norm <= n_norm;
        end
    end

    assign o_valid = r_out_valid;
    assign o_norm  = r_norm;

`ifndef SYNTHESIS
    a_deg_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_norm.degenerate |->
            o_norm.normal_x == '0 && o_norm.normal_y == '0 && o_norm.normal_z == '0)
        else $error("degenerate beat carries a nonzero normal");

    a_unit_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |->
            o_norm.normal_x <= UNIT && o_norm.normal_x >= -UNIT &&
            o_norm.normal_y <= UNIT && o_norm.normal_y >= -UNIT &&
            o_norm.normal_z <= UNIT && o_norm.normal_z >= -UNIT)
        else $error("normal component beyond unit length");

    a_nonzero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_norm.degenerate |->
            o_norm.normal_x != '0 || o_norm.normal_y != '0 || o_norm.normal_z != '0)
        else $error("regular triangle produced an all-zero normal");
`endif

endmodule

FILE: rtl/core/tfn_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfn_front
// Edges v1-v0 and v2-v0, their cross-term products, cross product, then magnitude and sign.
// ----------------------------------------------------------------------------
module tfn_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  tfn_pkg::t_tri i_tri,
    output logic          o_valid,
    output tfn_pkg::t_mag o_mag
);
    import tfn_pkg::*;

    logic                      r_v1, r_v2, r_v3, r_v4;
    logic signed [EDGE_W-1:0]  r_a [3];
    logic signed [EDGE_W-1:0]  r_b [3];
    logic signed [EDGE_W-1:0]  n_a [3];
    logic signed [EDGE_W-1:0]  n_b [3];
    logic signed [PROD_W-1:0]  r_p [6];
    logic signed [CROSS_W-1:0] r_c [3];
    t_mag                      r_mag;
    t_mag                      n_mag;
    logic signed [CROSS_W-1:0] n_c [3];

    always_comb begin
        n_a[0] = {i_tri.v1_x[COORD_WIDTH-1], i_tri.v1_x} - {i_tri.v0_x[COORD_WIDTH-1], i_tri.v0_x};
        n_a[1] = {i_tri.v1_y[COORD_WIDTH-1], i_tri.v1_y} - {i_tri.v0_y[COORD_WIDTH-1], i_tri.v0_y};
        n_a[2] = {i_tri.v1_z[COORD_WIDTH-1], i_tri.v1_z} - {i_tri.v0_z[COORD_WIDTH-1], i_tri.v0_z};
        n_b[0] = {i_tri.v2_x[COORD_WIDTH-1], i_tri.v2_x} - {i_tri.v0_x[COORD_WIDTH-1], i_tri.v0_x};
        n_b[1] = {i_tri.v2_y[COORD_WIDTH-1], i_tri.v2_y} - {i_tri.v0_y[COORD_WIDTH-1], i_tri.v0_y};
        n_b[2] = {i_tri.v2_z[COORD_WIDTH-1], i_tri.v2_z} - {i_tri.v0_z[COORD_WIDTH-1], i_tri.v0_z};
    end

    always_comb begin
        n_c[0] = CROSS_W'(r_p[0]) - CROSS_W'(r_p[1]);
        n_c[1] = CROSS_W'(r_p[2]) - CROSS_W'(r_p[3]);
        n_c[2] = CROSS_W'(r_p[4]) - CROSS_W'(r_p[5]);
        for (int j = 0; j < 3; j++) begin
            n_mag.neg[j] = r_c[j][CROSS_W-1];
            n_mag.mag[j] = r_c[j][CROSS_W-1] ? MAG_W'(-r_c[j]) : MAG_W'(r_c[j]);
        end
        n_mag.deg = (r_c[0] == '0) && (r_c[1] == '0) && (r_c[2] == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a    <= n_a;
            r_b    <= n_b;
            r_p[0] <= r_a[1] * r_b[2];
            r_p[1] <= r_a[2] * r_b[1];
            r_p[2] <= r_a[2] * r_b[0];
            r_p[3] <= r_a[0] * r_b[2];
            r_p[4] <= r_a[0] * r_b[1];
            r_p[5] <= r_a[1] * r_b[0];
            r_c    <= n_c;
            r_mag  <= n_mag;
        end
    end

    assign o_valid = r_v4;
    assign o_mag   = r_mag;

endmodule

FILE: rtl/core/tfn_square.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfn_square
// Split squares of the cross components, their sum, and the root seed.
// ----------------------------------------------------------------------------
module tfn_square (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  tfn_pkg::t_mag  i_mag,
    output logic           o_valid,
    output tfn_pkg::t_root o_root
);
    import tfn_pkg::*;

    logic                     r_v5, r_v6, r_v7, r_v8;
    logic [2*HI_W-1:0]        r_hh [3];
    logic [MAG_W-1:0]         r_hl [3];
    logic [2*HALF_W-1:0]      r_ll [3];
    logic [SQ_W-1:0]          r_sq [3];
    logic [SUM_W-1:0]         r_s;
    logic [ACC_W-1:0]         r_t [3];
    logic [2:0]               r_neg5, r_neg6, r_neg7;
    logic                     r_deg5, r_deg6, r_deg7;
    t_root                    r_root;
    t_root                    n_root;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            n_root.rem[j] = r_t[j] - ACC_W'(r_s);
            n_root.ms[j]  = ACC_W'(0) - ACC_W'(r_s);
            n_root.q[j]   = '0;
        end
        n_root.s   = r_s;
        n_root.neg = r_neg7;
        n_root.deg = r_deg7;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
            r_v7 <= 1'b0;
            r_v8 <= 1'b0;
        end else if (i_en) begin
            r_v5 <= i_valid;
            r_v6 <= r_v5;
            r_v7 <= r_v6;
            r_v8 <= r_v7;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < 3; j++) begin
                r_hh[j] <= i_mag.mag[j][MAG_W-1:HALF_W] * i_mag.mag[j][MAG_W-1:HALF_W];
                r_hl[j] <= i_mag.mag[j][MAG_W-1:HALF_W] * i_mag.mag[j][HALF_W-1:0];
                r_ll[j] <= i_mag.mag[j][HALF_W-1:0] * i_mag.mag[j][HALF_W-1:0];
                r_sq[j] <= (SQ_W'(r_hh[j]) << (2 * HALF_W))
                         + (SQ_W'(r_hl[j]) << (HALF_W + 1))
                         + SQ_W'(r_ll[j]);
                r_t[j]  <= ACC_W'(r_sq[j]) << (2 * FRAC_OUT + 2);
            end
            r_s    <= SUM_W'(r_sq[0]) + SUM_W'(r_sq[1]) + SUM_W'(r_sq[2]);
            r_neg5 <= i_mag.neg;
            r_deg5 <= i_mag.deg;
            r_neg6 <= r_neg5;
            r_deg6 <= r_deg5;
            r_neg7 <= r_neg6;
            r_deg7 <= r_deg6;
            r_root <= n_root;
        end
    end

    assign o_valid = r_v8;
    assign o_root  = r_root;

endmodule

FILE: rtl/core/tfn_root_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfn_root_step
// One quotient bit of the unit scaling search, for all three components.
// ----------------------------------------------------------------------------
module tfn_root_step #(
    parameter int K = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  tfn_pkg::t_root i_root,
    output logic           o_valid,
    output tfn_pkg::t_root o_root
);
    import tfn_pkg::*;

    logic                    r_valid;
    t_root                   r_root;
    t_root                   n_root;
    logic signed [ACC_W-1:0] s_ext;
    logic signed [ACC_W-1:0] dv [3];
    logic signed [ACC_W-1:0] rn [3];
    logic [2:0]              take;

    // Try bit K: m grows by 2^(K+1), so m^2*S grows by 2^(K+2)*m*S + 2^(2K+2)*S.
    always_comb begin
        n_root = i_root;
        s_ext  = $signed(ACC_W'(i_root.s));
        for (int j = 0; j < 3; j++) begin
            dv[j]   = ($signed(i_root.ms[j]) <<< (K + 2)) + (s_ext <<< (2 * K + 2));
            rn[j]   = $signed(i_root.rem[j]) - dv[j];
            take[j] = !i_root.q[j][FRAC_OUT] && !rn[j][ACC_W-1];
            if (take[j]) begin
                n_root.rem[j] = rn[j];
                n_root.q[j]   = i_root.q[j] | (Q_W'(1) << K);
                n_root.ms[j]  = $signed(i_root.ms[j]) + (s_ext <<< (K + 1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_root <= n_root;
        end
    end

    assign o_valid = r_valid;
    assign o_root  = r_root;

endmodule
